/* sv/pcg_pkg.sv */
// Shared types, constants and a helper function for the eight-lane PCG generator.
package pcg_pkg;
	localparam int LANES = 8;
	localparam int LANE_W = $clog2(LANES) > 0 ? $clog2(LANES) : 1;
	localparam int POS_W = $clog2(LANES + 1);
	localparam logic [31:0] PCG_MUL = 32'd747796405;
	localparam logic [31:0] PCG_PERM_MUL = 32'd277803737;
	localparam logic [31:0] PCG_INIT = 32'h46b56677;
	localparam logic CFG_USE_SEED = 1'b0;
	localparam logic CFG_SEED_VALUE = 1'b1;
	localparam logic OP_RAW = 1'b0;
	localparam logic OP_BOUNDED = 1'b1;

	typedef struct packed {
		logic        bounded;
		logic [31:0] bound;
	} cmd_t;

	function automatic logic [31:0] lane_inc(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'd67173735;
			3'd1: r = 32'd3210862681;
			3'd2: r = 32'd2725112281;
			3'd3: r = 32'd609188517;
			3'd4: r = 32'd995526969;
			3'd5: r = 32'd2351453077;
			3'd6: r = 32'd882272065;
			default: r = 32'd3278650715;
		endcase
		return r;
	endfunction
endpackage

/* sv/pcg_stream_if.sv */
// Valid/ready stream interface carrying a generic payload.
interface pcg_stream_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/pcg_front.sv */
// Front end: classifies requests and queues them for the draw engine.
module pcg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_opcode,
	input  logic [31:0]        in_bound,
	output logic               q_valid,
	input  logic               q_pop,
	output pcg_pkg::cmd_t      q_cmd
);
	import pcg_pkg::*;
	cmd_t   slot_q [2];
	logic   wr_q, rd_q;
	logic [1:0] cnt_q;
	logic   push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].bounded <= (in_opcode == OP_BOUNDED) && (in_bound != 32'd0);
			slot_q[wr_q].bound <= in_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

/* sv/pcg_divu.sv */
// Radix-2 restoring 32-bit unsigned remainder unit, one bit per cycle.
module pcg_divu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] rem
);
	logic [31:0] n_q, d_q;
	logic [32:0] r_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] sh;

	assign sh = {r_q[31:0], n_q[31]};
	assign rem = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[30:0], 1'b0};
			if (sh >= {1'b0, d_q}) r_q <= sh - {1'b0, d_q};
			else r_q <= sh;
		end
	end
endmodule

/* sv/pcg_back.sv */
// Back end: lane generators, output cache and rejection sampling sequencer.
module pcg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [31:0]   cfg_data,
	input  logic          q_valid,
	output logic          q_pop,
	input  pcg_pkg::cmd_t q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_value
);
	import pcg_pkg::*;

	localparam logic [3:0] ST_SEED0 = 4'd0, ST_SEED1 = 4'd1, ST_SEED2 = 4'd2,
		ST_IDLE = 4'd3, ST_THR = 4'd4, ST_DRAW = 4'd5, ST_PERM1 = 4'd6,
		ST_PERM2 = 4'd7, ST_PERM3 = 4'd8, ST_CHK = 4'd9, ST_MOD = 4'd10,
		ST_MODW = 4'd11, ST_OUT = 4'd12, ST_THRW = 4'd13;

	logic [3:0]        st_q;
	logic              use_seed_q;
	logic [31:0]       seed_q;
	logic [31:0]       lane_q [LANES];
	logic [31:0]       cache_q [LANES];
	logic [POS_W-1:0]  pos_q;
	logic [LANE_W-1:0] pi_q;
	logic [31:0]       p_s1, p_s2, r_q, thr_q, val_q, bound_q;
	logic [3:0]        sh_s1;
	logic              bnd_q, pend_q;
	logic              dv_start, dv_done;
	logic [31:0]       dv_num, dv_den, dv_rem;
	logic [63:0]       pm;
	logic [31:0]       px;
	logic              res_load;

	pcg_divu u_div (.clk, .arst_n, .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .rem(dv_rem));

	assign out_valid = pend_q;
	assign out_value = val_q;
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign dv_start = (st_q == ST_THR) || (st_q == ST_MOD);
	assign dv_num = (st_q == ST_THR) ? (32'd0 - bound_q) : r_q;
	assign dv_den = bound_q;
	assign px = (p_s1 >> ({28'd0, sh_s1} + 32'd4)) ^ p_s1;
	assign pm = {32'd0, px} * {32'd0, PCG_PERM_MUL};
	// A finished result moves into the output register only once that register is free.
	assign res_load = !cfg_we && (!pend_q || out_ready) &&
		((st_q == ST_CHK && !bnd_q) || st_q == ST_OUT);

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			bnd_q <= q_cmd.bounded;
			bound_q <= q_cmd.bound;
		end
		if (st_q == ST_PERM1) begin
			p_s1 <= lane_q[pi_q];
			sh_s1 <= lane_q[pi_q][31:28];
		end
		if (st_q == ST_PERM2) p_s2 <= pm[31:0];
		if (st_q == ST_PERM3) cache_q[pi_q] <= (p_s2 >> 22) ^ p_s2;
		if (st_q == ST_DRAW && pos_q != POS_W'(LANES)) r_q <= cache_q[pos_q[LANE_W-1:0]];
		if (st_q == ST_PERM3 && pi_q == '0) r_q <= (p_s2 >> 22) ^ p_s2;
		if (st_q == ST_THRW && dv_done) thr_q <= dv_rem;
		if (res_load) val_q <= bnd_q ? dv_rem : r_q;
	end

	// Lane updates: all lanes step their LCG in parallel, in seeding and per refill.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (cfg_we) begin
				lane_q[i] <= '0;
			end else if (st_q == ST_SEED0) begin
				lane_q[i] <= use_seed_q ? 32'd0 : PCG_INIT;
			end else if (st_q == ST_SEED1) begin
				lane_q[i] <= lane_q[i] * PCG_MUL + lane_inc(3'(i))
					+ (use_seed_q ? seed_q : 32'd0);
			end else if ((st_q == ST_SEED2 && use_seed_q) ||
			             (st_q == ST_PERM3 && pi_q == LANE_W'(LANES - 1))) begin
				lane_q[i] <= lane_q[i] * PCG_MUL + lane_inc(3'(i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_SEED0;
			use_seed_q <= 1'b0;
			seed_q <= '0;
			pos_q <= POS_W'(LANES);
			pi_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (res_load) pend_q <= 1'b1;
			else if (out_ready) pend_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == CFG_USE_SEED) use_seed_q <= cfg_data[0];
				else seed_q <= cfg_data;
				st_q <= ST_SEED0;
				pos_q <= POS_W'(LANES);
			end else begin
				case (st_q)
					ST_SEED0: st_q <= ST_SEED1;
					ST_SEED1: st_q <= ST_SEED2;
					ST_SEED2: st_q <= ST_IDLE;
					ST_IDLE: if (q_valid) st_q <= q_cmd.bounded ? ST_THR : ST_DRAW;
					ST_THR: st_q <= ST_THRW;
					ST_THRW: if (dv_done) st_q <= ST_DRAW;
					ST_DRAW: begin
						if (pos_q != POS_W'(LANES)) begin
							pos_q <= pos_q + POS_W'(1);
							st_q <= ST_CHK;
						end else begin
							pi_q <= '0;
							st_q <= ST_PERM1;
						end
					end
					ST_PERM1: st_q <= ST_PERM2;
					ST_PERM2: st_q <= ST_PERM3;
					ST_PERM3: begin
						if (pi_q == LANE_W'(LANES - 1)) begin
							pos_q <= POS_W'(1);
							st_q <= ST_CHK;
						end else begin
							pi_q <= pi_q + LANE_W'(1);
							st_q <= ST_PERM1;
						end
					end
					ST_CHK: begin
						if (!bnd_q) st_q <= res_load ? ST_IDLE : ST_OUT;
						else if (r_q >= thr_q) st_q <= ST_MOD;
						else st_q <= ST_DRAW;
					end
					ST_MOD: st_q <= ST_MODW;
					ST_MODW: if (dv_done) st_q <= ST_OUT;
					ST_OUT: if (res_load) st_q <= ST_IDLE;
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end
endmodule

/* sv/pcg_rxs_m_xs_8lane_rng.sv */
// Top level of the eight-lane PCG-RXS-M-XS random number generator.
//
//  Port group   Direction  Contents
//  req          sink       opcode, bound (word of one request)
//  rsp          source     value (word of one result)
//  cfg_*        input      write enable, register index, write data
//
// A raw draw served from the cache passes through the back end in pick-up, cache
// read and check; a cache refill runs each lane in turn through the single shared
// permutation multiplier.
// A bounded draw adds a remainder pass for the threshold and another for the final
// value, and repeats draws on each rejection.
// After reset or a register write the lanes are reseeded in the states SEED0 to SEED2.
// Requests queue in a two-entry buffer, so the front keeps taking words while a
// result waits for the consumer, until both entries are full.
module pcg_rxs_m_xs_8lane_rng (
	input  logic        clk,
	input  logic        arst_n,
	pcg_stream_if.sink   req,
	pcg_stream_if.source rsp,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data
);
	import pcg_pkg::*;

	logic  q_valid, q_pop;
	cmd_t  q_cmd;

	// The request word packs the opcode above the 32-bit bound.
	pcg_front u_front (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.in_opcode(req.data[32]), .in_bound(req.data[31:0]),
		.q_valid, .q_pop, .q_cmd
	);

	pcg_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.q_valid, .q_pop, .q_cmd,
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_value(rsp.data)
	);

	// A queue pop only happens when an entry is present.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");
	// A result held back by the consumer keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
		else $error("result changed while stalled");
endmodule
